// ----- rtl/core/speck128_block_cipher_unit_defines.svh -----
// Assertion macros for the cipher unit checker.
`ifndef SPECK128_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define SPECK128_BLOCK_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SPK_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SPK_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

// Fixed-delay implication.
`define SPK_ASSERT_DLY(lbl, clk, rst_n, a, n, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> ##(n) (c)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/spk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spk_pkg;

    localparam int WORD_W      = 64;
    localparam int ROUND_COUNT = 32;
    localparam int RK_IDX_W    = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam int ROT_A       = 8;
    localparam int ROT_B       = 3;
    localparam int CFG_IDX_W   = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);

    // opcodes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [WORD_W-1:0] block_low;
        logic [WORD_W-1:0] block_high;
    } t_spk_req;

    typedef struct packed {
        logic [WORD_W-1:0] out_low;
        logic [WORD_W-1:0] out_high;
    } t_spk_rsp;

    // round unit control
    typedef struct packed {
        logic decrypt;
    } t_spk_rnd_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/speck128_block_cipher_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Speck 128/128 cipher unit, one round per clock on a shared round unit.
// Result: the strobe is registered and rises after the last round.
// Requests: a new one is taken only once the previous one has finished all its rounds.
// Key change or reset: the key is loaded (S_KEY_LOAD) and expanded (S_EXPAND), busy stays high.
// Reset is synchronous, active low; keys clear and the all-zero key is expanded.
// The receiver cannot stall: each result shows for one cycle only.
module speck128_block_cipher_unit
    import spk_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // request channel
    input  wire                  start,
    output logic                 busy,
    input  wire t_spk_req        i_req,
    // result channel
    output logic                 o_rsp_valid,
    output t_spk_rsp             o_rsp,
    // configuration channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [WORD_W-1:0]     i_cfg_data
);

    localparam logic [RK_IDX_W-1:0] RK_LAST    = RK_IDX_W'(ROUND_COUNT - 1);
    localparam logic [RK_IDX_W-1:0] RK_PRELAST = RK_IDX_W'(ROUND_COUNT - 2);

    typedef enum logic [1:0] {
        S_KEY_LOAD,
        S_EXPAND,
        S_IDLE,
        S_ROUND
    } t_state;

    // Configuration: key registers and the rekey request flag.
    logic [WORD_W-1:0] r_key_low;
    logic [WORD_W-1:0] r_key_high;
    logic              cfg_wr;
    logic              key_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign key_wr      = cfg_wr && ((i_cfg_index == REG_KEY_LOW) ||
                                    (i_cfg_index == REG_KEY_HIGH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_index == REG_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end
            if (i_cfg_index == REG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
            end
        end
    end

    // Sequencer state and datapath registers.
    t_state            r_state,     n_state;
    logic              r_rekey,     n_rekey;
    logic [RK_IDX_W-1:0] r_cnt,     n_cnt;
    logic              r_op,        n_op;
    logic [WORD_W-1:0] r_x,         n_x;
    logic [WORD_W-1:0] r_y,         n_y;
    logic              r_rsp_valid, n_rsp_valid;
    t_spk_rsp          r_rsp,       n_rsp;

    // Shared round unit: key step during expansion, cipher round otherwise.
    t_spk_rnd_ctl      rnd_ctl;
    logic [WORD_W-1:0] rnd_rk;
    logic [WORD_W-1:0] rnd_x;
    logic [WORD_W-1:0] rnd_y;

    // Key store ports.
    logic                ks_we;
    logic [RK_IDX_W-1:0] ks_waddr;
    logic [WORD_W-1:0]   ks_wdata;
    logic [RK_IDX_W-1:0] ks_raddr;
    logic [WORD_W-1:0]   ks_rdata;

    logic req_take;

    // A pending key change holds requests off until the schedule is rebuilt.
    assign busy     = (r_state != S_IDLE) || r_rekey;
    assign req_take = start && !busy;

    always_comb begin
        rnd_ctl.decrypt = (r_state == S_ROUND) && (r_op == OP_DECRYPT);
        rnd_rk          = (r_state == S_EXPAND) ? WORD_W'(r_cnt) : ks_rdata;
    end

    spk_round_unit u_round (
        .i_ctl (rnd_ctl),
        .i_x   (r_x),
        .i_y   (r_y),
        .i_rk  (rnd_rk),
        .o_x   (rnd_x),
        .o_y   (rnd_y)
    );

    // Round key i is written at step i-1; key 0 is the low key word itself.
    always_comb begin
        ks_we    = 1'b0;
        ks_waddr = r_cnt + RK_IDX_W'(1);
        ks_wdata = rnd_y;
        case (r_state)
            S_KEY_LOAD: begin
                ks_we    = 1'b1;
                ks_waddr = '0;
                ks_wdata = r_key_low;
            end
            S_EXPAND: begin
                ks_we = 1'b1;
            end
            default: begin
                ks_we = 1'b0;
            end
        endcase
    end

    // Read address runs one round ahead, the store output is registered.
    always_comb begin
        if (r_state == S_ROUND) begin
            ks_raddr = (r_op == OP_DECRYPT) ? (RK_PRELAST - r_cnt)
                                            : (r_cnt + RK_IDX_W'(1));
        end else begin
            ks_raddr = (i_req.opcode == OP_DECRYPT) ? RK_LAST : '0;
        end
    end

    spk_key_store u_keys (
        .i_clk   (i_clk),
        .i_we    (ks_we),
        .i_waddr (ks_waddr),
        .i_wdata (ks_wdata),
        .i_raddr (ks_raddr),
        .o_rdata (ks_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_rekey     = r_rekey || key_wr;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_rsp_valid = 1'b0;
        n_rsp       = r_rsp;
        case (r_state)
            S_KEY_LOAD: begin
                // l in x, k in y
                n_rekey = key_wr;
                n_x     = r_key_high;
                n_y     = r_key_low;
                n_cnt   = '0;
                n_state = (ROUND_COUNT > 1) ? S_EXPAND : S_IDLE;
            end
            S_EXPAND: begin
                n_x   = rnd_x;
                n_y   = rnd_y;
                n_cnt = r_cnt + RK_IDX_W'(1);
                if (r_rekey) begin
                    // key rewritten mid-expansion: start over
                    n_state = S_KEY_LOAD;
                end else if (r_cnt == RK_PRELAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_take) begin
                    n_op    = i_req.opcode;
                    n_x     = i_req.block_high;
                    n_y     = i_req.block_low;
                    n_cnt   = '0;
                    n_state = S_ROUND;
                end else if (r_rekey) begin
                    n_state = S_KEY_LOAD;
                end
            end
            S_ROUND: begin
                n_x   = rnd_x;
                n_y   = rnd_y;
                n_cnt = r_cnt + RK_IDX_W'(1);
                if (r_cnt == RK_LAST) begin
                    n_rsp_valid    = 1'b1;
                    n_rsp.out_low  = rnd_y;
                    n_rsp.out_high = rnd_x;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_KEY_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_KEY_LOAD;
            r_rekey     <= 1'b0;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rekey     <= n_rekey;
            r_cnt       <= n_cnt;
            r_rsp_valid <= n_rsp_valid;
        end
        r_op  <= n_op;
        r_x   <= n_x;
        r_y   <= n_y;
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

// ----- rtl/core/spk_round_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One Speck round, forward or inverse. The key step is a forward round
// with the round index in place of the round key.
module spk_round_unit
    import spk_pkg::*;
(
    input  wire t_spk_rnd_ctl      i_ctl,
    input  wire logic [WORD_W-1:0] i_x,
    input  wire logic [WORD_W-1:0] i_y,
    input  wire logic [WORD_W-1:0] i_rk,
    output logic      [WORD_W-1:0] o_x,
    output logic      [WORD_W-1:0] o_y
);

    logic [WORD_W-1:0] x_enc;
    logic [WORD_W-1:0] y_enc;
    logic [WORD_W-1:0] x_dec;
    logic [WORD_W-1:0] y_dec;
    logic [WORD_W-1:0] y_xor;
    logic [WORD_W-1:0] x_sub;

    assign x_enc = (((i_x >> ROT_A) | (i_x << (WORD_W - ROT_A))) + i_y) ^ i_rk;
    assign y_enc = ((i_y << ROT_B) | (i_y >> (WORD_W - ROT_B))) ^ x_enc;

    assign y_xor = i_y ^ i_x;
    assign y_dec = (y_xor >> ROT_B) | (y_xor << (WORD_W - ROT_B));
    assign x_sub = (i_x ^ i_rk) - y_dec;
    assign x_dec = (x_sub << ROT_A) | (x_sub >> (WORD_W - ROT_A));

    assign o_x = i_ctl.decrypt ? x_dec : x_enc;
    assign o_y = i_ctl.decrypt ? y_dec : y_enc;

endmodule

`default_nettype wire

// ----- rtl/core/spk_key_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Round key memory: one write port, one registered read port.
module spk_key_store
    import spk_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [RK_IDX_W-1:0] i_waddr,
    input  wire [WORD_W-1:0] i_wdata,
    input  wire [RK_IDX_W-1:0] i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [ROUND_COUNT];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/spk_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "speck128_block_cipher_unit_defines.svh"

// Port-level checks on the cipher unit.
module spk_checker
    import spk_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 o_rsp_valid,
    input wire                 i_cfg_valid,
    input wire                 o_cfg_ready,
    input wire [CFG_IDX_W-1:0] i_cfg_index
);

    logic req_take;
    logic key_wr;

    assign req_take = start && !busy;
    assign key_wr   = i_cfg_valid && o_cfg_ready &&
                      ((i_cfg_index == REG_KEY_LOW) || (i_cfg_index == REG_KEY_HIGH));

    `SPK_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, req_take, busy)
    `SPK_ASSERT_DLY(a_rsp_latency, i_clk, i_rst_n, req_take, ROUND_COUNT + 1, o_rsp_valid)
    `SPK_ASSERT_NEXT(a_rsp_single, i_clk, i_rst_n, o_rsp_valid, !o_rsp_valid)
    `SPK_ASSERT_NEXT(a_busy_after_key, i_clk, i_rst_n, key_wr, busy)
    `SPK_ASSERT_IMP(a_no_take_at_rsp, i_clk, i_rst_n, o_rsp_valid, !$past(req_take))

endmodule

bind speck128_block_cipher_unit spk_checker u_spk_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the Speck 128/128 cipher unit.
// A driver pops queued requests and pulses start; a monitor compares every
// result strobe against the oldest predicted block. Keys are only rewritten
// once the unit has drained, so the predictor's round-key copy stays in step.
module testbench;
    import spk_pkg::*;

    // first register index past the key registers; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_KEY_HIGH + 1'b1;
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 130;
    // drain wait: room for a result still in flight, plus margin
    localparam int DRAIN_CYCLES = 2 * ROUND_COUNT + 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_spk_req             i_req = '0;
    logic                 o_rsp_valid;
    t_spk_rsp             o_rsp;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    // predictor state: shadow key registers and their expanded schedule
    logic [WORD_W-1:0] key_low_shadow = '0;
    logic [WORD_W-1:0] key_high_shadow = '0;
    logic [WORD_W-1:0] round_keys [ROUND_COUNT];

    t_spk_req    pending_blocks [$];   // requests not yet issued
    t_spk_rsp    expected_blocks [$];  // predicted outputs, oldest first
    int unsigned error_count = 0;
    int unsigned idle_left = 0;
    bit          idle_enable = 1'b0;

    speck128_block_cipher_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] rot_right(input logic [WORD_W-1:0] v,
                                                     input int unsigned r);
        return (v >> r) | (v << (WORD_W - r));
    endfunction

    function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v,
                                                    input int unsigned r);
        return (v << r) | (v >> (WORD_W - r));
    endfunction

    // Key schedule: round key 0 is the low key word, each step folds the
    // step index into l and derives the next k from it.
    function automatic void expand_round_keys();
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] l;
        k = key_low_shadow;
        l = key_high_shadow;
        round_keys[0] = k;
        for (int i = 0; i < ROUND_COUNT - 1; i++) begin
            l = (rot_right(l, ROT_A) + k) ^ WORD_W'(i);
            k = rot_left(k, ROT_B) ^ l;
            round_keys[i + 1] = k;
        end
    endfunction

    // Full 32-round encrypt or decrypt of one block with the current schedule.
    function automatic t_spk_rsp speck_transform(input t_spk_req rq);
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        t_spk_rsp          rs;
        y = rq.block_low;
        x = rq.block_high;
        if (rq.opcode == OP_ENCRYPT) begin
            for (int i = 0; i < ROUND_COUNT; i++) begin
                x = (rot_right(x, ROT_A) + y) ^ round_keys[i];
                y = rot_left(y, ROT_B) ^ x;
            end
        end else begin
            // inverse rounds, keys taken last to first
            for (int i = 0; i < ROUND_COUNT; i++) begin
                y = rot_right(y ^ x, ROT_B);
                x = rot_left((x ^ round_keys[ROUND_COUNT - 1 - i]) - y, ROT_A);
            end
        end
        rs.out_low  = y;
        rs.out_high = x;
        return rs;
    endfunction

    //------------------------------------------------------------------
    // Request driver
    //------------------------------------------------------------------
    // All inputs change only on rising edges through NBAs. busy is read in the
    // active region, so it is the value the unit saw at this edge.
    // A request is taken at an edge with start high and busy low; the
    // prediction is made right there, against the schedule in force.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                expected_blocks.push_back(speck_transform(i_req));
            end
            // start held while busy; otherwise the slot is free for the next one
            if (!start || !busy) begin
                if (idle_left != 0) begin
                    idle_left <= idle_left - 1;
                    start     <= 1'b0;
                end else if (pending_blocks.size() != 0) begin
                    i_req <= pending_blocks.pop_front();
                    start <= 1'b1;
                    // idle burst lands before the following request
                    if (idle_enable && $urandom_range(0, 3) == 0) begin
                        idle_left <= $urandom_range(1, 8);
                    end else begin
                        idle_left <= 0;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Result monitor
    //------------------------------------------------------------------
    // One-cycle strobe, no back-pressure: every strobe is a result.
    always @(posedge i_clk) begin
        t_spk_rsp want;
        if (i_rst_n && o_rsp_valid) begin
            if (expected_blocks.size() == 0) begin
                $error("result with no request outstanding: %h %h",
                       o_rsp.out_high, o_rsp.out_low);
                error_count++;
            end else begin
                want = expected_blocks.pop_front();
                if (o_rsp.out_low !== want.out_low) begin
                    $error("out_low mismatch: expected %h, actual %h",
                           want.out_low, o_rsp.out_low);
                    error_count++;
                end
                if (o_rsp.out_high !== want.out_high) begin
                    $error("out_high mismatch: expected %h, actual %h",
                           want.out_high, o_rsp.out_high);
                    error_count++;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------
    // Returns at a rising edge once nothing is queued, issued or in flight.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_blocks.size() != 0 || expected_blocks.size() != 0 || start || busy);
    endtask

    // Config write; called at a rising edge. Ends at the edge after the
    // handshake so back-to-back writes never double-drive valid.
    task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [WORD_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_KEY_LOW) begin
            key_low_shadow = value;
            expand_round_keys();
        end else if (idx == REG_KEY_HIGH) begin
            key_high_shadow = value;
            expand_round_keys();
        end
        // other indexes are dropped, schedule untouched
        @(posedge i_clk);
    endtask

    task automatic queue_block(input logic op, input logic [WORD_W-1:0] lo,
                               input logic [WORD_W-1:0] hi);
        t_spk_req rq;
        rq.opcode     = op;
        rq.block_low  = lo;
        rq.block_high = hi;
        pending_blocks.push_back(rq);
    endtask

    // mostly random words, now and then an all-zero or all-one word
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return {$urandom, $urandom};
            end
        endcase
    endfunction

    //------------------------------------------------------------------
    // Test sequence
    //------------------------------------------------------------------
    initial begin
        t_spk_req enc_rq;
        t_spk_rsp ct;
        logic     op;
        bit       lost_results;

        expand_round_keys();  // reset schedule: all-zero key
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_enable = 1'b1;

        // reset schedule, untouched key registers
        wait_drained();
        queue_block(OP_ENCRYPT, '0, '0);
        queue_block(OP_DECRYPT, '0, '0);
        queue_block(OP_ENCRYPT, '1, '1);
        queue_block(OP_DECRYPT, '1, '1);
        wait_drained();

        // published 128/128 vector, plus alternating bit patterns
        write_key_reg(REG_KEY_LOW, 64'h0706050403020100);
        write_key_reg(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
        queue_block(OP_ENCRYPT, 64'h7469206564616d20, 64'h6c61766975716520);
        queue_block(OP_DECRYPT, 64'h7860fedf5c570d18, 64'ha65d985179783265);
        queue_block(OP_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        queue_block(OP_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        wait_drained();

        // writes past the key registers must leave the schedule alone
        write_key_reg(REG_FIRST_UNUSED, '1);
        write_key_reg('1, {$urandom, $urandom});
        queue_block(OP_ENCRYPT, 64'h7469206564616d20, 64'h6c61766975716520);
        queue_block(OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
        wait_drained();

        // all-ones key
        write_key_reg(REG_KEY_LOW, '1);
        write_key_reg(REG_KEY_HIGH, '1);
        queue_block(OP_ENCRYPT, '0, '1);
        queue_block(OP_DECRYPT, '1, '0);
        queue_block(OP_ENCRYPT, '1, '1);
        queue_block(OP_DECRYPT, '0, '0);
        wait_drained();

        // rewrite of a single key register
        write_key_reg(REG_KEY_LOW, '0);
        queue_block(OP_ENCRYPT, '0, '0);
        queue_block(OP_DECRYPT, '1, '1);
        wait_drained();

        // random phases; last one runs with no idle gaps
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: begin
                    write_key_reg(REG_KEY_LOW, pick_word());
                end
                1: begin
                    write_key_reg(REG_KEY_HIGH, pick_word());
                end
                default: begin
                    write_key_reg(REG_KEY_LOW, pick_word());
                    write_key_reg(REG_KEY_HIGH, pick_word());
                end
            endcase
            if ($urandom_range(0, 3) == 0) begin
                write_key_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, 255)),
                              {$urandom, $urandom});
            end
            if (ph == RANDOM_PHASES - 1) begin
                idle_enable = 1'b0;
            end else begin
                idle_enable = ($urandom_range(0, 3) != 0);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                op = 1'($urandom_range(0, 1));
                if (op == OP_DECRYPT && $urandom_range(0, 1) == 0) begin
                    // round trip: decrypt a ciphertext made under the same key
                    enc_rq.opcode     = OP_ENCRYPT;
                    enc_rq.block_low  = pick_word();
                    enc_rq.block_high = pick_word();
                    ct = speck_transform(enc_rq);
                    queue_block(OP_DECRYPT, ct.out_low, ct.out_high);
                end else begin
                    queue_block(op, pick_word(), pick_word());
                end
            end
            wait_drained();
        end

        // drain margin, then verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        lost_results = (expected_blocks.size() != 0);
        if (lost_results) begin
            $error("%0d results never arrived", expected_blocks.size());
        end
        if (error_count == 0 && !lost_results) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hang guard: far above the slowest legal run
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/spk_pkg.sv
rtl/core/spk_round_unit.sv
rtl/core/spk_key_store.sv
rtl/core/speck128_block_cipher_unit.sv
rtl/core/spk_checker.sv
tb/sv/testbench.sv
